// ----- hdl/register_memory_instruction_executor_macros.svh -----
// Assertion macros for the register/memory instruction executor.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef REGISTER_MEMORY_INSTRUCTION_EXECUTOR_MACROS_SVH
`define REGISTER_MEMORY_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RMIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define RMIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rmie_pkg.sv -----
// Shared types, constants and helpers of the instruction executor.
// No dependencies; used by every other file but the assertion macros header.
package rmie_pkg;

  localparam int NUM_REGS   = 16;
  localparam int MEM_WORDS  = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int PROG_DEPTH = 1024;

  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int IDX_W  = $clog2(PROG_DEPTH);
  localparam int RIDX_W = 4;
  localparam int CNT_W  = $clog2(DATA_WIDTH);

  localparam logic [RIDX_W-1:0] NO_BASE  = 4'd14;
  localparam logic [RIDX_W-1:0] BAD_BASE = 4'd15;

  // Fault codes
  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_DISP     = 3'd1;
  localparam logic [2:0] FLT_BASE     = 3'd2;
  localparam logic [2:0] FLT_REG      = 3'd3;
  localparam logic [2:0] FLT_RANGE    = 3'd4;

  // Status codes
  localparam logic [1:0] STS_ZERO = 2'd0;
  localparam logic [1:0] STS_POS  = 2'd1;
  localparam logic [1:0] STS_NEG  = 2'd2;
  localparam logic [1:0] STS_DIVZ = 2'd3;

  typedef enum logic [4:0] {
    CMD_A    = 5'd0,  CMD_AR = 5'd1,  CMD_S  = 5'd2,  CMD_SR = 5'd3,
    CMD_M    = 5'd4,  CMD_MR = 5'd5,  CMD_D  = 5'd6,  CMD_DR = 5'd7,
    CMD_C    = 5'd8,  CMD_CR = 5'd9,  CMD_J  = 5'd10, CMD_JZ = 5'd11,
    CMD_JP   = 5'd12, CMD_JN = 5'd13, CMD_L  = 5'd14, CMD_LA = 5'd15,
    CMD_LR   = 5'd16, CMD_ST = 5'd17, CMD_READ = 5'd18
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_BASE, ST_RD, ST_OPND, ST_EXEC, ST_DIV, ST_OUT
  } state_e;

  // Classified instruction held in the queue
  typedef struct packed {
    logic [4:0]            cmd;
    logic [RIDX_W-1:0]     reg_dst;
    logic [RIDX_W-1:0]     reg_src;
    logic [RIDX_W-1:0]     base_reg;
    logic [11:0]           disp;
    logic [9:0]            target;
    logic [DATA_WIDTH-1:0] imm_value;
    logic                  is_mem;
    logic                  is_rr;
    logic [2:0]            pre_fault;
  } item_t;

  // Queue head towards the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Back-end control towards the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

  function automatic logic [1:0] sign_state(input logic [DATA_WIDTH-1:0] v);
    logic [1:0] s;
    if (v == '0) s = STS_ZERO;
    else if (v[DATA_WIDTH-1]) s = STS_NEG;
    else s = STS_POS;
    return s;
  endfunction

endpackage

// ----- hdl/rmie_in_if.sv -----
// Input channel of the instruction executor: valid/ready plus instruction fields.
// Depends on rmie_pkg.
interface rmie_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [4:0]                           cmd;
  logic [3:0]                           reg_dst;
  logic [3:0]                           reg_src;
  logic [3:0]                           base_reg;
  logic [11:0]                          disp;
  logic [9:0]                           target;
  logic signed [rmie_pkg::DATA_WIDTH-1:0] imm_value;

  modport source (output valid, cmd, reg_dst, reg_src, base_reg, disp, target, imm_value,
                  input ready);
  modport sink (input valid, cmd, reg_dst, reg_src, base_reg, disp, target, imm_value,
                output ready);
endinterface

// ----- hdl/rmie_out_if.sv -----
// Result channel of the instruction executor: valid/ready plus result fields.
// Depends on rmie_pkg.
interface rmie_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [9:0]                           next_index;
  logic [1:0]                           status;
  logic [2:0]                           fault;
  logic                                 reg_written;
  logic [3:0]                           written_reg;
  logic signed [rmie_pkg::DATA_WIDTH-1:0] written_value;

  modport source (output valid, next_index, status, fault, reg_written, written_reg,
                  written_value, input ready);
  modport sink (input valid, next_index, status, fault, reg_written, written_reg,
                written_value, output ready);
endinterface

// ----- hdl/rmie_front.sv -----
// Front end: accepts instruction words, classifies them, holds a two-entry queue.
// Depends on rmie_pkg and rmie_in_if.
module rmie_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rmie_in_if.sink             in_i,
  input  rmie_pkg::bk_ctl_t   ctl_i,
  output rmie_pkg::q_head_t   head_o
);

  rmie_pkg::item_t ent_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  rmie_pkg::item_t cls;
  logic            known, uses_rd;

  // Classify the incoming word
  always_comb begin
    cls           = '0;
    cls.cmd       = in_i.cmd;
    cls.reg_dst   = in_i.reg_dst;
    cls.reg_src   = in_i.reg_src;
    cls.base_reg  = in_i.base_reg;
    cls.disp      = in_i.disp;
    cls.target    = in_i.target;
    cls.imm_value = in_i.imm_value;
    known   = (in_i.cmd <= rmie_pkg::CMD_READ);
    uses_rd = known;
    cls.is_mem = 1'b0;
    cls.is_rr  = 1'b0;
    case (in_i.cmd) inside
      rmie_pkg::CMD_A, rmie_pkg::CMD_S, rmie_pkg::CMD_M, rmie_pkg::CMD_D, rmie_pkg::CMD_C,
      rmie_pkg::CMD_L, rmie_pkg::CMD_LA, rmie_pkg::CMD_ST: cls.is_mem = 1'b1;
      rmie_pkg::CMD_READ: begin
        cls.is_mem = 1'b1;
        uses_rd    = 1'b0;
      end
      rmie_pkg::CMD_AR, rmie_pkg::CMD_SR, rmie_pkg::CMD_MR, rmie_pkg::CMD_DR,
      rmie_pkg::CMD_CR, rmie_pkg::CMD_LR: cls.is_rr = 1'b1;
      rmie_pkg::CMD_J, rmie_pkg::CMD_JZ, rmie_pkg::CMD_JP, rmie_pkg::CMD_JN: uses_rd = 1'b0;
      default: ;
    endcase
    // Faults visible from the word alone, in priority order
    if ((uses_rd && int'(in_i.reg_dst) >= rmie_pkg::NUM_REGS) ||
        (cls.is_rr && int'(in_i.reg_src) >= rmie_pkg::NUM_REGS))
      cls.pre_fault = rmie_pkg::FLT_REG;
    else if (cls.is_mem && in_i.disp[1:0] != 2'b00)
      cls.pre_fault = rmie_pkg::FLT_DISP;
    else if (cls.is_mem && in_i.base_reg != rmie_pkg::NO_BASE &&
             (in_i.base_reg == rmie_pkg::BAD_BASE ||
              int'(in_i.base_reg) >= rmie_pkg::NUM_REGS))
      cls.pre_fault = rmie_pkg::FLT_REG;
    else
      cls.pre_fault = rmie_pkg::FLT_NONE;
  end

  assign in_i.ready   = (cnt_q != 2'd2) && !ctl_i.clearing;
  assign push         = in_i.valid && in_i.ready;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = ent_q[rd_ptr_q];

  // Store the classified word
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= cls;
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (ctl_i.pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(ctl_i.pop);
    end
  end

endmodule

// ----- hdl/rmie_div.sv -----
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rmie_pkg.
module rmie_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rmie_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [rmie_pkg::DATA_WIDTH-1:0] divisor_i,
  output logic                            done_o,
  output logic [rmie_pkg::DATA_WIDTH-1:0] quot_o
);

  localparam int W = rmie_pkg::DATA_WIDTH;

  logic                        busy_q, done_q, neg_q;
  logic [rmie_pkg::CNT_W-1:0]  cnt_q;
  logic [W-1:0]                rem_q, quo_q, dvs_q;
  logic [W:0]                  shift, diff;

  assign shift  = {rem_q, quo_q[W-1]};
  assign diff   = shift - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rmie_pkg::CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitudes, then shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_q <= divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      rem_q <= diff[W] ? shift[W-1:0] : diff[W-1:0];
      quo_q <= {quo_q[W-2:0], ~diff[W]};
    end
  end

endmodule

// ----- hdl/rmie_back.sv -----
// Back end: register file, data memory, sequencer that carries out one word at a time.
// Depends on rmie_pkg, rmie_out_if and rmie_div.
module rmie_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmie_pkg::q_head_t head_i,
  output rmie_pkg::bk_ctl_t ctl_o,
  rmie_out_if.source        out_o
);

  localparam int W = rmie_pkg::DATA_WIDTH;
  localparam int A = rmie_pkg::ADDR_W;

  rmie_pkg::state_e state_q, state_d;
  logic [A-1:0]     clr_q;
  rmie_pkg::item_t  item_q;

  // Storage
  logic [W-1:0] rf_mem [rmie_pkg::NUM_REGS];
  logic [W-1:0] dm_mem [rmie_pkg::MEM_WORDS];
  logic [W-1:0] rf_rdata_q, dm_rdata_q;
  logic [rmie_pkg::RIDX_W-1:0] rf_raddr, rf_waddr;
  logic         rf_we, dm_we;
  logic [W-1:0] rf_wdata, dm_wdata;
  logic [A-1:0] dm_waddr;

  // Per-word registers
  logic [2:0]   fault_q;
  logic [A-1:0] word_q;
  logic [W-1:0] a_q, opnd_q;
  logic [1:0]   status_q;
  logic [rmie_pkg::IDX_W-1:0] idx_q;

  // Pending result
  logic [rmie_pkg::IDX_W-1:0] p_next;
  logic [1:0]   p_status;
  logic [2:0]   p_fault;
  logic         p_wr, p_mwr;
  logic [rmie_pkg::RIDX_W-1:0] p_wreg;
  logic [W-1:0] p_wval;

  // Execute-stage values
  logic [rmie_pkg::IDX_W-1:0] ex_next;
  logic [1:0]   ex_status;
  logic         ex_wr, ex_mwr, ex_div;
  logic [rmie_pkg::RIDX_W-1:0] ex_wreg;
  logic [W-1:0] ex_wval;

  // Address check values
  logic [W:0]   addr;
  logic [2:0]   ag_fault;
  logic         has_base;

  logic         out_valid_q, slot_free, commit;
  logic         div_start, div_done;
  logic [W-1:0] div_quot;

  rmie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (opnd_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign slot_free = !out_valid_q || out_o.ready;
  assign commit    = (state_q == rmie_pkg::ST_OUT) && slot_free;

  // Work out fault and word index from the base value
  always_comb begin
    has_base = (item_q.base_reg != rmie_pkg::NO_BASE);
    if (has_base) addr = {rf_rdata_q[W-1], rf_rdata_q} + (W+1)'(item_q.disp);
    else addr = (W+1)'(item_q.disp);
    ag_fault = rmie_pkg::FLT_NONE;
    if (item_q.pre_fault != rmie_pkg::FLT_NONE)
      ag_fault = item_q.pre_fault;
    else if (item_q.is_mem) begin
      if (has_base && rf_rdata_q[1:0] != 2'b00)
        ag_fault = rmie_pkg::FLT_BASE;
      else if (has_base && $signed(rf_rdata_q) > $signed((W)'(rmie_pkg::MEM_WORDS * 4)))
        ag_fault = rmie_pkg::FLT_RANGE;
      else if (addr[W] || addr[W:2] >= (W-1)'(rmie_pkg::MEM_WORDS))
        ag_fault = rmie_pkg::FLT_RANGE;
    end
  end

  // Carry out the word
  always_comb begin
    ex_next   = idx_q + 1'b1;
    ex_status = status_q;
    ex_wr     = 1'b0;
    ex_mwr    = 1'b0;
    ex_div    = 1'b0;
    ex_wreg   = '0;
    ex_wval   = '0;
    if (fault_q != rmie_pkg::FLT_NONE) begin
      ex_next = idx_q;
    end else begin
      case (item_q.cmd) inside
        rmie_pkg::CMD_A, rmie_pkg::CMD_AR, rmie_pkg::CMD_S, rmie_pkg::CMD_SR,
        rmie_pkg::CMD_M, rmie_pkg::CMD_MR: begin
          if (item_q.cmd == rmie_pkg::CMD_A || item_q.cmd == rmie_pkg::CMD_AR)
            ex_wval = a_q + opnd_q;
          else if (item_q.cmd == rmie_pkg::CMD_S || item_q.cmd == rmie_pkg::CMD_SR)
            ex_wval = a_q - opnd_q;
          else
            ex_wval = a_q * opnd_q;
          ex_wr     = 1'b1;
          ex_wreg   = item_q.reg_dst;
          ex_status = rmie_pkg::sign_state(ex_wval);
        end
        rmie_pkg::CMD_D, rmie_pkg::CMD_DR: begin
          if (opnd_q == '0) ex_status = rmie_pkg::STS_DIVZ;
          else ex_div = 1'b1;
        end
        rmie_pkg::CMD_C, rmie_pkg::CMD_CR: begin
          if ($signed(a_q) > $signed(opnd_q)) ex_status = rmie_pkg::STS_POS;
          else if (a_q == opnd_q) ex_status = rmie_pkg::STS_ZERO;
          else ex_status = rmie_pkg::STS_NEG;
        end
        rmie_pkg::CMD_J: ex_next = item_q.target;
        rmie_pkg::CMD_JZ: if (status_q == rmie_pkg::STS_ZERO) ex_next = item_q.target;
        rmie_pkg::CMD_JP: if (status_q == rmie_pkg::STS_POS) ex_next = item_q.target;
        rmie_pkg::CMD_JN: if (status_q == rmie_pkg::STS_NEG) ex_next = item_q.target;
        rmie_pkg::CMD_L, rmie_pkg::CMD_LR, rmie_pkg::CMD_LA: begin
          ex_wval = (item_q.cmd == rmie_pkg::CMD_LA) ? W'({word_q, 2'b00}) : opnd_q;
          ex_wr   = 1'b1;
          ex_wreg = item_q.reg_dst;
        end
        rmie_pkg::CMD_ST: begin
          ex_wval = a_q;
          ex_mwr  = 1'b1;
        end
        rmie_pkg::CMD_READ: begin
          ex_wval = item_q.imm_value;
          ex_mwr  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Next state, read addresses and write ports
  always_comb begin
    state_d   = state_q;
    ctl_o.pop = 1'b0;
    ctl_o.clearing = (state_q == rmie_pkg::ST_CLEAR);
    rf_raddr  = head_i.item.base_reg;
    rf_we     = 1'b0;
    rf_waddr  = p_wreg;
    rf_wdata  = p_wval;
    dm_we     = 1'b0;
    dm_waddr  = word_q;
    dm_wdata  = p_wval;
    div_start = 1'b0;
    unique case (state_q)
      rmie_pkg::ST_CLEAR: begin
        rf_we    = 1'b1;
        rf_waddr = clr_q[rmie_pkg::RIDX_W-1:0];
        rf_wdata = '0;
        dm_we    = 1'b1;
        dm_waddr = clr_q;
        dm_wdata = '0;
        if (clr_q == A'(rmie_pkg::MEM_WORDS - 1)) state_d = rmie_pkg::ST_IDLE;
      end
      rmie_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          ctl_o.pop = 1'b1;
          state_d   = rmie_pkg::ST_BASE;
        end
      end
      rmie_pkg::ST_BASE: begin
        rf_raddr = item_q.reg_dst;
        state_d  = rmie_pkg::ST_RD;
      end
      rmie_pkg::ST_RD: begin
        rf_raddr = item_q.reg_src;
        state_d  = rmie_pkg::ST_OPND;
      end
      rmie_pkg::ST_OPND: state_d = rmie_pkg::ST_EXEC;
      rmie_pkg::ST_EXEC: begin
        div_start = ex_div;
        state_d   = ex_div ? rmie_pkg::ST_DIV : rmie_pkg::ST_OUT;
      end
      rmie_pkg::ST_DIV: if (div_done) state_d = rmie_pkg::ST_OUT;
      rmie_pkg::ST_OUT: begin
        if (slot_free) begin
          rf_we   = p_wr;
          dm_we   = p_mwr;
          state_d = rmie_pkg::ST_IDLE;
        end
      end
      default: state_d = rmie_pkg::ST_IDLE;
    endcase
  end

  // Register file and data memory, registered reads
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_rdata_q <= rf_mem[rf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
    dm_rdata_q <= dm_mem[word_q];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmie_pkg::ST_CLEAR;
      clr_q       <= '0;
      status_q    <= rmie_pkg::STS_ZERO;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rmie_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (commit) begin
        status_q    <= p_status;
        idx_q       <= p_next;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-word datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      rmie_pkg::ST_IDLE: if (head_i.valid) item_q <= head_i.item;
      rmie_pkg::ST_BASE: begin
        fault_q <= ag_fault;
        word_q  <= addr[A+1:2];
      end
      rmie_pkg::ST_RD: a_q <= rf_rdata_q;
      rmie_pkg::ST_OPND: opnd_q <= item_q.is_mem ? dm_rdata_q : rf_rdata_q;
      rmie_pkg::ST_EXEC: begin
        p_next   <= ex_next;
        p_status <= ex_status;
        p_fault  <= fault_q;
        p_wr     <= ex_wr;
        p_mwr    <= ex_mwr;
        p_wreg   <= ex_wreg;
        p_wval   <= ex_wval;
      end
      rmie_pkg::ST_DIV: begin
        if (div_done) begin
          p_wr     <= 1'b1;
          p_wreg   <= item_q.reg_dst;
          p_wval   <= div_quot;
          p_status <= rmie_pkg::sign_state(div_quot);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_o.next_index    <= p_next;
      out_o.status        <= p_status;
      out_o.fault         <= p_fault;
      out_o.reg_written   <= p_wr;
      out_o.written_reg   <= p_wreg;
      out_o.written_value <= p_wval;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ----- hdl/register_memory_instruction_executor.sv -----
// Register/memory instruction executor, one instruction word in, one result word out.
// Divides go through the 32-step radix-2 divider.
// The back-end sequencer carries out one word at a time; a two-entry queue takes
// words while the back end works.
// Reset: asynchronous; a sweep then clears data memory and registers,
// during which no word is accepted.
`include "register_memory_instruction_executor_macros.svh"

module register_memory_instruction_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmie_in_if.sink     in_i,
  rmie_out_if.source  out_o
);

  rmie_pkg::q_head_t head;
  rmie_pkg::bk_ctl_t ctl;

  rmie_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctl_i  (ctl),
    .head_o (head)
  );

  rmie_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .ctl_o  (ctl),
    .out_o  (out_o)
  );

  // Hold off input during the clearing sweep
  `RMIE_ASSERT_NOW(a_no_accept_clear, ctl.clearing, !in_i.ready, "word taken while clearing")
  // A faulted word writes no register
  `RMIE_ASSERT_NOW(a_fault_no_write, out_o.valid && out_o.fault != rmie_pkg::FLT_NONE,
                   !out_o.reg_written, "register written on fault")
  // Hold a stalled result word until it is taken
  `RMIE_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid,
                    "result word dropped while stalled")
  // Never pop an empty queue
  `RMIE_ASSERT_NOW(a_pop_valid, ctl.pop, head.valid, "pop of empty queue")

endmodule
